[hw/rtl/casa_pkg.sv]
// ----------------------------------------------------------------------------
// casa_pkg
// Shared types, codes and default sizes for the call argument slot allocator.
// ----------------------------------------------------------------------------
package casa_pkg;

	// Default sizes of the register files and counters
	localparam int CORE_ARG_REGS_DEF     = 4;
	localparam int VFP_ARG_REGS_DEF      = 16;
	localparam int MAX_ARGS_DEF          = 256;
	localparam int STACK_OFFSET_BITS_DEF = 16;

	// Structs above this size go by hidden pointer on the callee side
	localparam logic [9:0] BIG_STRUCT_BYTES = 10'd16;

	// Reset value of the stack alignment register
	localparam logic [2:0] STACK_ALIGN_RESET = 3'd3;
	localparam logic [2:0] STACK_ALIGN_MIN   = 3'd2;
	localparam logic [2:0] STACK_ALIGN_MAX   = 3'd6;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_HARD_FLOAT  = 2'd0,
		CFG_VARIADIC    = 2'd1,
		CFG_STACK_ALIGN = 2'd2,
		CFG_CALLEE_SIDE = 2'd3
	} cfg_index_t;

	// Argument kinds
	localparam logic [1:0] KIND_WORD   = 2'd0;
	localparam logic [1:0] KIND_DWORD  = 2'd1;
	localparam logic [1:0] KIND_STRUCT = 2'd2;

	// Location kinds
	typedef enum logic [1:0] {
		LOC_REG   = 2'd0,
		LOC_STACK = 2'd1,
		LOC_SPLIT = 2'd2,
		LOC_VFP   = 2'd3
	} loc_kind_t;

endpackage

[hw/rtl/call_argument_slot_allocator_unit.sv]
// ----------------------------------------------------------------------------
// call_argument_slot_allocator_unit
// Places procedure-call arguments in core registers, VFP registers or the
// outgoing stack area, one descriptor per cycle while in_stall is low.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   new_call, arg_pos, arg_kind,
//                                             fp_arg, arg_size, arg_align
//   out      output     out_valid / out_stall loc_kind, first_reg, num_regs,
//                                             stack_offset, stack_part_bytes,
//                                             loc_size, invisible_ref,
//                                             total_stack_bytes, args_seen,
//                                             stack_overflow
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One descriptor per cycle while in_stall is low; its result passes through the
// input register and the result register and transfers while out_stall is low.
// The placement counters update in the same single pass from the input
// register to the result register, so the next descriptor sees them at once.
// Reset clears the counters and loads the configuration defaults.
// out_stall holds the result register and reaches in_stall only when both
// registers are full.
// ----------------------------------------------------------------------------
module call_argument_slot_allocator_unit #(
	parameter int CORE_ARG_REGS     = casa_pkg::CORE_ARG_REGS_DEF,
	parameter int VFP_ARG_REGS      = casa_pkg::VFP_ARG_REGS_DEF,
	parameter int MAX_ARGS          = casa_pkg::MAX_ARGS_DEF,
	parameter int STACK_OFFSET_BITS = casa_pkg::STACK_OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        new_call,
	input  logic [7:0]  arg_pos,
	input  logic [1:0]  arg_kind,
	input  logic        fp_arg,
	input  logic [9:0]  arg_size,
	input  logic [4:0]  arg_align,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  loc_kind,
	output logic [3:0]  first_reg,
	output logic [2:0]  num_regs,
	output logic [15:0] stack_offset,
	output logic [9:0]  stack_part_bytes,
	output logic [9:0]  loc_size,
	output logic        invisible_ref,
	output logic [15:0] total_stack_bytes,
	output logic [8:0]  args_seen,
	output logic        stack_overflow,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);

	localparam int SB       = STACK_OFFSET_BITS;
	localparam int W        = SB + 11;
	localparam int NCW      = $clog2(CORE_ARG_REGS + 2);
	localparam int NVW      = $clog2(VFP_ARG_REGS + 1);
	localparam int ACNT_LIM = (MAX_ARGS > 256) ? 256 : MAX_ARGS;

	localparam logic [W-1:0]   STK_MAX = {{11{1'b0}}, {SB{1'b1}}};
	localparam logic [NCW-1:0] CORE_N  = NCW'(CORE_ARG_REGS);
	localparam logic [NVW-1:0] VFP_N   = NVW'(VFP_ARG_REGS);
	localparam logic [8:0]     ACNT_N  = 9'(ACNT_LIM);

	// Configuration registers
	logic       hard_float_q;
	logic       variadic_q;
	logic [2:0] stack_align_q;
	logic       callee_side_q;

	// Placement state
	logic [NCW-1:0] next_core_q;
	logic [NVW-1:0] next_vfp_q;
	logic [SB-1:0]  next_stack_q;
	logic [8:0]     arg_count_q;

	// Input register
	logic       valid_s1;
	logic       new_call_s1;
	logic [7:0] arg_pos_s1;
	logic [1:0] arg_kind_s1;
	logic       fp_arg_s1;
	logic [9:0] arg_size_s1;
	logic [4:0] arg_align_s1;

	// Result register
	logic                valid_s2;
	casa_pkg::loc_kind_t loc_kind_s2;
	logic [3:0]          first_reg_s2;
	logic [2:0]          num_regs_s2;
	logic [15:0]         stack_offset_s2;
	logic [9:0]          stack_part_s2;
	logic [9:0]          loc_size_s2;
	logic                iref_s2;
	logic [15:0]         total_s2;
	logic [8:0]          args_seen_s2;
	logic                overflow_s2;

	// Single-pass placement results
	casa_pkg::loc_kind_t lkind;
	logic [3:0]          rbase;
	logic [2:0]          rcount;
	logic [SB-1:0]       soff;
	logic [10:0]         spart;
	logic [9:0]          lsize;
	logic                iref;
	logic [SB-1:0]       total;
	logic                ov;
	logic [NCW-1:0]      nc_nxt;
	logic [NVW-1:0]      nv_nxt;
	logic [SB-1:0]       ns_nxt;
	logic [8:0]          ac_nxt;

	logic adv_s1;
	logic load_s1;
	logic cfg_we;

	assign adv_s1   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign load_s1  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_we   = cfg_valid && cfg_ready;

	// Place one argument against the current counters
	always_comb begin
		logic [NCW-1:0] nc0;
		logic [NCW-1:0] nce;
		logic [NCW-1:0] ncs;
		logic [NCW-1:0] avail;
		logic [NVW-1:0] nv0;
		logic [SB-1:0]  ns0;
		logic [8:0]     ac0;
		logic [8:0]     idx1;
		logic [4:0]     align;
		logic [3:0]     amask;
		logic [10:0]    slot;
		logic [8:0]     words;
		logic           vfp_sel;
		logic           do_stk;
		logic [3:0]     rmask;
		logic [10:0]    add_amt;
		logic [W-1:0]   rnd;
		logic [W-1:0]   base;
		logic [W-1:0]   sum;
		logic [W-1:0]   nxt;
		logic [2:0]     lg;
		logic [6:0]     tmask;
		logic [W-1:0]   trnd;

		// Start of call clears all counters
		nc0 = new_call_s1 ? '0 : next_core_q;
		nv0 = new_call_s1 ? '0 : next_vfp_q;
		ns0 = new_call_s1 ? '0 : next_stack_q;
		ac0 = new_call_s1 ? '0 : arg_count_q;

		// Track highest argument position plus one, saturate at the limit
		idx1   = {1'b0, arg_pos_s1} + 9'd1;
		ac_nxt = (ac0 < idx1) ? idx1 : ac0;
		if (ac_nxt > ACNT_N) begin
			ac_nxt = ACNT_N;
		end

		// Effective alignment: 4, 8 or 16
		if (arg_align_s1 >= 5'd16) begin
			align = 5'd16;
		end else if (arg_align_s1 >= 5'd8) begin
			align = 5'd8;
		end else begin
			align = 5'd4;
		end
		amask = 4'(align - 5'd1);

		slot  = ({1'b0, arg_size_s1} + 11'd3) & ~11'd3;
		words = slot[10:2];
		nce   = nc0 + NCW'(nc0[0]);
		ncs   = (align >= 5'd8 && nc0[0]) ? nc0 + NCW'(1) : nc0;
		avail = CORE_N - ncs;

		vfp_sel = hard_float_q && !variadic_q && fp_arg_s1 && arg_size_s1 == 10'd4;

		lkind   = casa_pkg::LOC_STACK;
		rbase   = '0;
		rcount  = '0;
		spart   = '0;
		lsize   = arg_size_s1;
		iref    = 1'b0;
		nc_nxt  = nc0;
		nv_nxt  = nv0;
		do_stk  = 1'b0;
		rmask   = '0;
		add_amt = '0;

		if (vfp_sel) begin
			if (nv0 < VFP_N) begin
				lkind  = casa_pkg::LOC_VFP;
				rbase  = 4'(nv0);
				rcount = 3'd1;
				nv_nxt = nv0 + NVW'(1);
			end else begin
				do_stk  = 1'b1;
				rmask   = 4'd3;
				add_amt = 11'd4;
			end
		end else begin
			case (arg_kind_s1)
				casa_pkg::KIND_DWORD: begin
					if (11'(nce) + 11'd2 <= 11'(CORE_ARG_REGS)) begin
						lkind  = casa_pkg::LOC_REG;
						rbase  = 4'(nce);
						rcount = 3'd2;
						nc_nxt = nce + NCW'(2);
					end else begin
						do_stk  = 1'b1;
						rmask   = 4'd7;
						add_amt = 11'd8;
						nc_nxt  = CORE_N;
					end
				end
				casa_pkg::KIND_STRUCT: begin
					if (arg_size_s1 > casa_pkg::BIG_STRUCT_BYTES && callee_side_q) begin
						iref  = 1'b1;
						lsize = 10'd4;
						if (nc0 < CORE_N) begin
							lkind  = casa_pkg::LOC_REG;
							rbase  = 4'(nc0);
							rcount = 3'd1;
							nc_nxt = nc0 + NCW'(1);
						end else begin
							do_stk  = 1'b1;
							add_amt = 11'd4;
						end
					end else if (11'(ncs) + 11'(words) <= 11'(CORE_ARG_REGS)) begin
						lkind  = casa_pkg::LOC_REG;
						rbase  = 4'(ncs);
						rcount = 3'(words);
						nc_nxt = ncs + NCW'(words);
					end else if (ncs < CORE_N) begin
						lkind   = casa_pkg::LOC_SPLIT;
						rbase   = 4'(ncs);
						rcount  = 3'(avail);
						spart   = (11'(words) - 11'(avail)) << 2;
						do_stk  = 1'b1;
						rmask   = amask;
						add_amt = spart;
						nc_nxt  = CORE_N;
					end else begin
						do_stk  = 1'b1;
						rmask   = amask;
						add_amt = slot;
						nc_nxt  = CORE_N;
					end
				end
				default: begin
					if (nc0 < CORE_N) begin
						lkind  = casa_pkg::LOC_REG;
						rbase  = 4'(nc0);
						rcount = 3'd1;
						nc_nxt = nc0 + NCW'(1);
					end else begin
						do_stk  = 1'b1;
						rmask   = 4'd3;
						add_amt = 11'd4;
						nc_nxt  = CORE_N;
					end
				end
			endcase
		end

		// Align the stack slot, then reserve it, saturating both steps
		ov   = 1'b0;
		rnd  = (W'(ns0) + W'(rmask)) & ~W'(rmask);
		base = rnd;
		if (rnd > STK_MAX) begin
			base = STK_MAX;
			ov   = 1'b1;
		end
		sum = base + W'(add_amt);
		nxt = sum;
		if (sum > STK_MAX) begin
			nxt = STK_MAX;
			ov  = 1'b1;
		end
		if (!do_stk) begin
			nxt = W'(ns0);
		end
		soff   = do_stk ? SB'(base) : '0;
		ns_nxt = SB'(nxt);

		// Round the stack area to the configured alignment
		lg = stack_align_q;
		if (lg < casa_pkg::STACK_ALIGN_MIN) begin
			lg = casa_pkg::STACK_ALIGN_MIN;
		end
		if (lg > casa_pkg::STACK_ALIGN_MAX) begin
			lg = casa_pkg::STACK_ALIGN_MAX;
		end
		tmask = 7'((8'd1 << lg) - 8'd1);
		trnd  = (W'(ns_nxt) + W'(tmask)) & ~W'(tmask);
		total = SB'(trnd);
		if (trnd > STK_MAX) begin
			total = SB'(STK_MAX);
			ov    = 1'b1;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_float_q  <= 1'b0;
			variadic_q    <= 1'b0;
			stack_align_q <= casa_pkg::STACK_ALIGN_RESET;
			callee_side_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (casa_pkg::cfg_index_t'(cfg_index))
				casa_pkg::CFG_HARD_FLOAT:  hard_float_q  <= cfg_data[0];
				casa_pkg::CFG_VARIADIC:    variadic_q    <= cfg_data[0];
				casa_pkg::CFG_STACK_ALIGN: stack_align_q <= cfg_data;
				casa_pkg::CFG_CALLEE_SIDE: callee_side_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Valid bits and placement counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			next_core_q  <= '0;
			next_vfp_q   <= '0;
			next_stack_q <= '0;
			arg_count_q  <= '0;
		end else begin
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && adv_s1) begin
				next_core_q  <= nc_nxt;
				next_vfp_q   <= nv_nxt;
				next_stack_q <= ns_nxt;
				arg_count_q  <= ac_nxt;
			end
		end
	end

	// Capture the descriptor on transfer
	always_ff @(posedge clk) begin
		if (load_s1) begin
			new_call_s1  <= new_call;
			arg_pos_s1   <= arg_pos;
			arg_kind_s1  <= arg_kind;
			fp_arg_s1    <= fp_arg;
			arg_size_s1  <= arg_size;
			arg_align_s1 <= arg_align;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			loc_kind_s2     <= lkind;
			first_reg_s2    <= rbase;
			num_regs_s2     <= rcount;
			stack_offset_s2 <= 16'(soff);
			stack_part_s2   <= spart[9:0];
			loc_size_s2     <= lsize;
			iref_s2         <= iref;
			total_s2        <= 16'(total);
			args_seen_s2    <= ac_nxt;
			overflow_s2     <= ov;
		end
	end

	assign out_valid         = valid_s2;
	assign loc_kind          = loc_kind_s2;
	assign first_reg         = first_reg_s2;
	assign num_regs          = num_regs_s2;
	assign stack_offset      = stack_offset_s2;
	assign stack_part_bytes  = stack_part_s2;
	assign loc_size          = loc_size_s2;
	assign invisible_ref     = iref_s2;
	assign total_stack_bytes = total_s2;
	assign args_seen         = args_seen_s2;
	assign stack_overflow    = overflow_s2;

`ifndef SYNTHESIS
	a_core_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_core_q <= CORE_N)
		else $error("core register counter past the last register");

	a_vfp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_vfp_q <= VFP_N)
		else $error("VFP register counter past the last register");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |-> in_stall)
		else $error("input taken while both registers are full and stalled");

	a_vfp_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && loc_kind == casa_pkg::LOC_VFP |->
			num_regs == 3'd1 && stack_offset == 16'd0 && !invisible_ref)
		else $error("VFP placement with bad register count or stack part");

	a_iref_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invisible_ref |-> loc_size == 10'd4 && stack_part_bytes == 10'd0)
		else $error("hidden reference with wrong size");
`endif

endmodule
